FILE: design/itf_pkg.sv
package itf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_DIGITS = 128;
    localparam int RAW_DIGITS = 64;
    localparam int WORD_CHARS = 8;
    localparam int OUT_CAP    = 32 * WORD_CHARS;

    localparam int NR_W  = $clog2(RAW_DIGITS + 1);
    localparam int LEN_W = 10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;

    localparam int FL_LEFT  = 0;
    localparam int FL_PLUS  = 1;
    localparam int FL_SPACE = 2;
    localparam int FL_ZERO  = 3;
    localparam int FL_ALT   = 4;
    localparam int FL_GRP   = 5;
    localparam int FL_UPPER = 6;
    localparam int FL_PREC  = 7;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_LAYOUT, S_START, S_LPAD, S_PRE, S_ZPAD, S_DIGS, S_RPAD, S_EMPTY
    } t_state;

    typedef enum logic [2:0] {
        SEG_LPAD, SEG_PRE, SEG_ZPAD, SEG_DIGS, SEG_RPAD
    } t_seg;

    typedef struct packed {
        logic ready;
        logic div_step;
        logic layout;
        logic seg_load;
        t_seg load_sel;
        logic emit;
        t_seg emit_sel;
        logic emit_empty;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic val_zero;
        logic step_zero;
        logic seg_zero;
        logic seg_one;
        logic last_char;
        logic out_busy;
        logic field_empty;
    } t_stat;

endpackage

FILE: design/itf_in_if.sv
interface itf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        negative;
    logic        signed_conv;
    logic [5:0]  base;
    logic [7:0]  fmt_flags;
    logic [8:0]  field_width;
    logic [7:0]  min_digits;

    modport source (output valid, value, negative, signed_conv, base, fmt_flags,
                    field_width, min_digits, input ready);
    modport sink   (input valid, value, negative, signed_conv, base, fmt_flags,
                    field_width, min_digits, output ready);
endinterface

FILE: design/itf_out_if.sv
interface itf_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] chars;
    logic [3:0]  char_count;
    logic        last;
    logic [8:0]  total_length;

    modport source (output valid, chars, char_count, last, total_length, input ready);
    modport sink   (input valid, chars, char_count, last, total_length, output ready);
endinterface

FILE: design/itf_ctrl.sv
module itf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  itf_pkg::t_stat i_stat,
    output itf_pkg::t_cmd  o_cmd
);
    import itf_pkg::*;

    t_state r_state, n_state;

    function automatic t_seg seg_of(input t_state s);
        case (s)
            S_LPAD:  seg_of = SEG_LPAD;
            S_PRE:   seg_of = SEG_PRE;
            S_ZPAD:  seg_of = SEG_ZPAD;
            S_DIGS:  seg_of = SEG_DIGS;
            default: seg_of = SEG_RPAD;
        endcase
    endfunction

    function automatic t_state next_seg(input t_state s);
        case (s)
            S_LPAD:  next_seg = S_PRE;
            S_PRE:   next_seg = S_ZPAD;
            S_ZPAD:  next_seg = S_DIGS;
            S_DIGS:  next_seg = S_RPAD;
            default: next_seg = S_IDLE;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.load_sel = SEG_LPAD;
        o_cmd.emit_sel = seg_of(r_state);
        case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.step_zero && i_stat.val_zero) begin
                    n_state = S_LAYOUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_LAYOUT: begin
                o_cmd.layout = 1'b1;
                n_state      = S_START;
            end
            S_START: begin
                if (i_stat.field_empty) begin
                    n_state = S_EMPTY;
                end else begin
                    o_cmd.seg_load = 1'b1;
                    o_cmd.load_sel = SEG_LPAD;
                    n_state        = S_LPAD;
                end
            end
            S_EMPTY: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_LPAD, S_PRE, S_ZPAD, S_DIGS, S_RPAD: begin
                o_cmd.load_sel = seg_of(next_seg(r_state));
                if (i_stat.seg_zero) begin
                    o_cmd.seg_load = (next_seg(r_state) != S_IDLE);
                    n_state        = next_seg(r_state);
                end else if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_char) begin
                        n_state = S_IDLE;
                    end else if (i_stat.seg_one) begin
                        o_cmd.seg_load = (next_seg(r_state) != S_IDLE);
                        n_state        = next_seg(r_state);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/itf_dpath.sv
module itf_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  itf_pkg::t_cmd  i_cmd,
    output itf_pkg::t_stat o_stat,
    itf_in_if.sink         i_in,
    itf_out_if.source      o_out
);
    import itf_pkg::*;

    logic [63:0]     r_val;
    logic [5:0]      r_rem;
    logic [2:0]      r_step;
    logic [5:0]      r_db;
    logic [7:0]      r_pre [3];
    logic [1:0]      r_np;
    logic            r_up, r_left, r_zpad, r_grp;
    logic [8:0]      r_md, r_fw;
    logic [5:0]      r_stk [RAW_DIGITS];
    logic [NR_W-1:0] r_nr;

    logic [8:0]       r_pad, r_nd, r_zleft, r_n, r_pos;
    logic [1:0]       r_m3;
    logic             r_first, r_cdone;
    logic [LEN_W-1:0] r_seg;

    logic [63:0] r_word;
    logic [3:0]  r_wc;

    logic        r_ovld;
    logic [63:0] r_ochars;
    logic [3:0]  r_ocnt;
    logic        r_olast;
    logic [8:0]  r_otot;

    logic        load;
    logic [7:0]  fl;
    logic [8:0]  md_sat, fw_sat;
    logic [7:0]  pre [3];
    logic [1:0]  np;
    logic        v_zero;

    logic [63:0] dv;
    logic [6:0]  rr;

    logic [8:0]       ndr, zeros, ncomma, nd, pad, n;
    logic [16:0]      prod0, prod1;
    logic [8:0]       q0;
    logic [1:0]       m3;
    logic             grp_on;
    logic [LEN_W-1:0] body, len, seg_len;

    logic        comma_now;
    logic [7:0]  ch;
    logic [63:0] n_word;
    logic        last_char;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic up);
        if (d < 6'd10) begin
            digit_char = CH_ZERO + {2'b00, d};
        end else begin
            digit_char = (up ? CH_UP_A : CH_LO_A) + {2'b00, d} - 8'd10;
        end
    endfunction

    assign load        = i_in.valid && i_in.ready;
    assign i_in.ready  = i_cmd.ready && i_rst_n;
    assign fl          = i_in.fmt_flags;
    assign v_zero      = (i_in.value == 64'd0);
    assign md_sat      = ({1'b0, i_in.min_digits} > 9'(MAX_DIGITS)) ? 9'(MAX_DIGITS)
                                                                    : {1'b0, i_in.min_digits};
    assign fw_sat      = (i_in.field_width > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : i_in.field_width;

    // Build the sign and alternate-form prefix.
    always_comb begin
        pre[0] = CH_SPACE;
        pre[1] = CH_SPACE;
        pre[2] = CH_SPACE;
        np     = 2'd0;
        if (i_in.signed_conv) begin
            if (i_in.negative) begin
                pre[np] = CH_MINUS; np = np + 2'd1;
            end else if (fl[FL_PLUS]) begin
                pre[np] = CH_PLUS;  np = np + 2'd1;
            end else if (fl[FL_SPACE]) begin
                pre[np] = CH_SPACE; np = np + 2'd1;
            end
        end
        if (fl[FL_ALT] && !v_zero) begin
            if (i_in.base == 6'd8) begin
                pre[np] = CH_ZERO; np = np + 2'd1;
            end else if (i_in.base == 6'd16) begin
                pre[np] = CH_ZERO; np = np + 2'd1;
                pre[np] = fl[FL_UPPER] ? CH_UP_X : CH_LO_X; np = np + 2'd1;
            end else if (i_in.base == 6'd2) begin
                pre[np] = CH_ZERO; np = np + 2'd1;
                pre[np] = fl[FL_UPPER] ? CH_UP_B : CH_LO_B; np = np + 2'd1;
            end
        end
    end

    // Eight restoring division steps per cycle; quotient bits shift in at the bottom.
    always_comb begin
        dv = r_val;
        rr = {1'b0, r_rem};
        for (int k = 0; k < 8; k++) begin
            rr = {rr[5:0], dv[63]};
            dv = {dv[62:0], 1'b0};
            if (rr >= {1'b0, r_db}) begin
                rr    = rr - {1'b0, r_db};
                dv[0] = 1'b1;
            end
        end
    end

    // Field layout from the finished digit count.
    always_comb begin
        ndr    = (r_md > 9'(r_nr)) ? r_md : 9'(r_nr);
        zeros  = ndr - 9'(r_nr);
        grp_on = r_grp && (ndr != 9'd0);
        prod0  = 17'(ndr) * 17'd171;
        prod1  = 17'(ndr - 9'd1) * 17'd171;
        q0     = {1'b0, prod0[16:9]};
        m3     = 2'(ndr - 9'(q0 * 9'd3));
        ncomma = grp_on ? {1'b0, prod1[16:9]} : 9'd0;
        nd     = ndr + ncomma;
        body   = LEN_W'(r_np) + LEN_W'(nd);
        pad    = (LEN_W'(r_fw) > body) ? 9'(LEN_W'(r_fw) - body) : 9'd0;
        len    = body + LEN_W'(pad);
        n      = (len > LEN_W'(OUT_CAP)) ? 9'(OUT_CAP) : 9'(len);
    end

    always_comb begin
        case (i_cmd.load_sel)
            SEG_LPAD: seg_len = (!r_left && !r_zpad) ? LEN_W'(r_pad) : '0;
            SEG_PRE:  seg_len = LEN_W'(r_np);
            SEG_ZPAD: seg_len = r_zpad ? LEN_W'(r_pad) : '0;
            SEG_DIGS: seg_len = LEN_W'(r_nd);
            SEG_RPAD: seg_len = r_left ? LEN_W'(r_pad) : '0;
            default:  seg_len = '0;
        endcase
    end

    // Character for the current position.
    always_comb begin
        comma_now = r_grp && !r_first && (r_m3 == 2'd0) && !r_cdone;
        case (i_cmd.emit_sel)
            SEG_PRE:  ch = r_pre[2'(r_np - r_seg[1:0])];
            SEG_ZPAD: ch = CH_ZERO;
            SEG_DIGS: begin
                if (comma_now) begin
                    ch = CH_COMMA;
                end else if (r_zleft != 9'd0) begin
                    ch = CH_ZERO;
                end else begin
                    ch = digit_char(r_stk[0], r_up);
                end
            end
            default:  ch = CH_SPACE;
        endcase
        n_word                    = r_word;
        n_word[r_wc[2:0]*8 +: 8]  = ch;
        last_char                 = ((r_pos + 9'd1) == r_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_ovld <= 1'b0;
            end
            if (i_cmd.emit_empty || (i_cmd.emit && (r_wc == 4'd7 || last_char))) begin
                r_ovld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val    <= i_in.value;
            r_rem    <= 6'd0;
            r_step   <= 3'd0;
            r_db     <= (i_in.base >= 6'd2 && i_in.base <= 6'd36) ? i_in.base : 6'd10;
            r_pre    <= pre;
            r_np     <= np;
            r_up     <= fl[FL_UPPER];
            r_left   <= fl[FL_LEFT];
            r_zpad   <= fl[FL_ZERO] && !fl[FL_PREC] && !fl[FL_LEFT];
            r_grp    <= fl[FL_GRP] && (i_in.base == 6'd10);
            r_md     <= md_sat;
            r_fw     <= fw_sat;
            r_stk[0] <= 6'd0;
            r_nr     <= (v_zero && !(md_sat == 9'd0 && fl[FL_PREC])) ? NR_W'(1) : '0;
        end
        if (i_cmd.div_step) begin
            r_val  <= dv;
            r_step <= r_step + 3'd1;
            if (r_step == 3'd7) begin
                r_rem    <= 6'd0;
                r_stk[0] <= rr[5:0];
                for (int k = 1; k < RAW_DIGITS; k++) begin
                    r_stk[k] <= r_stk[k-1];
                end
                r_nr <= r_nr + NR_W'(1);
            end else begin
                r_rem <= rr[5:0];
            end
        end
        if (i_cmd.layout) begin
            r_pad   <= pad;
            r_nd    <= nd;
            r_zleft <= zeros;
            r_m3    <= m3;
            r_grp   <= grp_on;
            r_first <= 1'b1;
            r_cdone <= 1'b0;
            r_n     <= n;
            r_pos   <= 9'd0;
            r_word  <= 64'd0;
            r_wc    <= 4'd0;
        end
        if (i_cmd.emit) begin
            r_seg <= r_seg - LEN_W'(1);
            r_pos <= r_pos + 9'd1;
            if (r_wc == 4'd7 || last_char) begin
                r_ochars <= n_word;
                r_ocnt   <= r_wc + 4'd1;
                r_olast  <= last_char;
                r_otot   <= last_char ? r_n : 9'd0;
                r_word   <= 64'd0;
                r_wc     <= 4'd0;
            end else begin
                r_word <= n_word;
                r_wc   <= r_wc + 4'd1;
            end
            if (i_cmd.emit_sel == SEG_DIGS) begin
                if (comma_now) begin
                    r_cdone <= 1'b1;
                end else begin
                    r_first <= 1'b0;
                    r_cdone <= 1'b0;
                    r_m3    <= (r_m3 == 2'd0) ? 2'd2 : r_m3 - 2'd1;
                    if (r_zleft != 9'd0) begin
                        r_zleft <= r_zleft - 9'd1;
                    end else begin
                        for (int k = 0; k < RAW_DIGITS - 1; k++) begin
                            r_stk[k] <= r_stk[k+1];
                        end
                    end
                end
            end
        end
        if (i_cmd.seg_load) begin
            r_seg <= seg_len;
        end
        if (i_cmd.emit_empty) begin
            r_ochars <= 64'd0;
            r_ocnt   <= 4'd0;
            r_olast  <= 1'b1;
            r_otot   <= 9'd0;
        end
    end

    assign o_stat.in_valid    = i_in.valid;
    assign o_stat.val_zero    = (r_val == 64'd0);
    assign o_stat.step_zero   = (r_step == 3'd0);
    assign o_stat.seg_zero    = (r_seg == '0);
    assign o_stat.seg_one     = (r_seg == LEN_W'(1));
    assign o_stat.last_char   = last_char;
    assign o_stat.out_busy    = r_ovld && !o_out.ready;
    assign o_stat.field_empty = (r_n == 9'd0);

    assign o_out.valid        = r_ovld;
    assign o_out.chars        = r_ochars;
    assign o_out.char_count   = r_ocnt;
    assign o_out.last         = r_olast;
    assign o_out.total_length = r_otot;

    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> (o_out.char_count == 4'd8))
        else $error("partial word before end of field");
    a_len_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> (o_out.total_length == 9'd0))
        else $error("field length shown on a non-final word");
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.char_count == 4'd0) |-> (o_out.last && o_out.total_length == 9'd0))
        else $error("empty word must close an empty field");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_empty) |-> !(r_ovld && !o_out.ready))
        else $error("character emitted while output word is stalled");

endmodule

FILE: design/integer_text_formatter_unit.sv
// Integer text formatter: printf-style conversion of a 64-bit magnitude.
//
// Input channel i_in (valid/ready): one word carries the magnitude, the sign
// and signed-conversion bits, base, format flags, field width and precision.
// Output channel o_out (valid/ready): the formatted field as words of up to
// eight ASCII characters, first character in the lowest byte; last marks the
// final word, which also carries total_length. An empty field gives one word
// with char_count 0 and last set.
//
// One request is handled at a time. After the accept, the digits are extracted
// by a long division by the base, eight quotient bits per cycle. The field is
// then laid out and generated one character per cycle while the receiver does
// not stall, each field segment, empty ones included, being walked in turn.
//
// Reset clears the controller and the output valid and holds ready low. When
// the receiver stalls, the pending word holds and character generation waits;
// a new request is taken once the previous field has been fully handed to the
// output register.
module integer_text_formatter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itf_in_if.sink    i_in,
    itf_out_if.source o_out
);
    import itf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequence the request: divide, lay out, then walk the field segments.
    itf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold the request, the digit stack, the segment counters and the output word.
    itf_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

FILE: dv/integer_text_formatter_unit_test.sv
module integer_text_formatter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import itf_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    // one input word of the format request
    typedef struct {
        logic [63:0] value;
        logic        negative;
        logic        signed_conv;
        logic [5:0]  base;
        logic [7:0]  fmt_flags;
        logic [8:0]  field_width;
        logic [7:0]  min_digits;
    } fmt_req_t;

    // one output word of formatted text
    typedef struct {
        logic [63:0] chars;
        logic [3:0]  char_count;
        logic        last;
        logic [8:0]  total_length;
    } text_word_t;

    // Formats each accepted request into its output words and checks them in order.
    class text_scoreboard;
        text_word_t pending[$];
        int         errors;

        function void note_request(fmt_req_t r);
            byte         prefix[$];
            byte         digits[$];
            byte         grouped[$];
            byte         field[$];
            logic [63:0] v;
            int          fw, md, radix, pad, n, nw, cnt;
            bit          f_left, f_plus, f_space, f_zero, f_alt, f_grp, f_up, f_prec;
            byte         d;
            text_word_t  w;
            v       = r.value;
            f_left  = r.fmt_flags[FL_LEFT];
            f_plus  = r.fmt_flags[FL_PLUS];
            f_space = r.fmt_flags[FL_SPACE];
            f_zero  = r.fmt_flags[FL_ZERO];
            f_alt   = r.fmt_flags[FL_ALT];
            f_grp   = r.fmt_flags[FL_GRP];
            f_up    = r.fmt_flags[FL_UPPER];
            f_prec  = r.fmt_flags[FL_PREC];
            fw = (r.field_width > MAX_WIDTH) ? MAX_WIDTH : r.field_width;
            md = (r.min_digits > MAX_DIGITS) ? MAX_DIGITS : r.min_digits;
            if (r.signed_conv) begin
                if (r.negative) prefix.push_back(CH_MINUS);
                else if (f_plus) prefix.push_back(CH_PLUS);
                else if (f_space) prefix.push_back(CH_SPACE);
            end
            if (f_alt && v != 0) begin
                if (r.base == 8) prefix.push_back(CH_ZERO);
                else if (r.base == 16) begin
                    prefix.push_back(CH_ZERO);
                    prefix.push_back(f_up ? CH_UP_X : CH_LO_X);
                end else if (r.base == 2) begin
                    prefix.push_back(CH_ZERO);
                    prefix.push_back(f_up ? CH_UP_B : CH_LO_B);
                end
            end
            radix = (r.base >= 2 && r.base <= 36) ? r.base : 10;
            // build digits most significant first
            if (!(v == 0 && md == 0 && f_prec)) begin
                if (v == 0) digits.push_back(CH_ZERO);
                while (v != 0) begin
                    d = byte'(v % radix);
                    digits.push_front(d < 10 ? CH_ZERO + d
                                             : (f_up ? CH_UP_A : CH_LO_A) + d - 10);
                    v = v / radix;
                end
            end
            while (digits.size() < md) digits.push_front(CH_ZERO);
            // commas only on a real base-10 request with digits present
            if (f_grp && r.base == 10 && digits.size() > 0) begin
                foreach (digits[i]) begin
                    if (i > 0 && (digits.size() - i) % 3 == 0) grouped.push_back(CH_COMMA);
                    grouped.push_back(digits[i]);
                end
                digits = grouped;
            end
            pad = fw - int'(prefix.size() + digits.size());
            if (pad < 0) pad = 0;
            if (f_left) begin
                field = {prefix, digits};
                repeat (pad) field.push_back(CH_SPACE);
            end else if (f_zero && !f_prec) begin
                field = prefix;
                repeat (pad) field.push_back(CH_ZERO);
                field = {field, digits};
            end else begin
                repeat (pad) field.push_back(CH_SPACE);
                field = {field, prefix, digits};
            end
            n = (field.size() > OUT_CAP) ? OUT_CAP : field.size();
            if (n == 0) begin
                w.chars = '0; w.char_count = 0; w.last = 1; w.total_length = 0;
                pending.push_back(w);
                return;
            end
            nw = (n + WORD_CHARS - 1) / WORD_CHARS;
            for (int i = 0; i < nw; i++) begin
                cnt = n - i * WORD_CHARS;
                if (cnt > WORD_CHARS) cnt = WORD_CHARS;
                w.chars = '0;
                for (int k = 0; k < cnt; k++) w.chars[8*k +: 8] = field[i*WORD_CHARS + k];
                w.char_count   = cnt;
                w.last         = (i == nw - 1);
                w.total_length = w.last ? n : 0;
                pending.push_back(w);
            end
        endfunction

        function void check_word(text_word_t got);
            text_word_t exp_w;
            if (pending.size() == 0) begin
                $error("unexpected word chars=%h", got.chars);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.chars !== exp_w.chars) begin
                $error("chars: expected %h, got %h", exp_w.chars, got.chars); errors++;
            end
            if (got.char_count !== exp_w.char_count) begin
                $error("char_count: expected %0d, got %0d", exp_w.char_count,
                       got.char_count);
                errors++;
            end
            if (got.last !== exp_w.last) begin
                $error("last: expected %0b, got %0b", exp_w.last, got.last); errors++;
            end
            if (got.total_length !== exp_w.total_length) begin
                $error("total_length: expected %0d, got %0d", exp_w.total_length,
                       got.total_length);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    itf_in_if  req_ch();
    itf_out_if txt_ch();

    integer_text_formatter_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch.sink),
        .o_out  (txt_ch.source)
    );

    always #5 i_clk = ~i_clk;

    text_scoreboard board = new();
    int  cycle_count = 0;
    bit  long_hold = 0;   // receiver holds off while set
    bit  stim_done = 0;
    int  burst_left = 0;

    initial begin
        req_ch.valid = 0;
        req_ch.value = 0;
        req_ch.negative = 0;
        req_ch.signed_conv = 0;
        req_ch.base = 10;
        req_ch.fmt_flags = 0;
        req_ch.field_width = 0;
        req_ch.min_digits = 0;
        txt_ch.ready = 0;
    end

    // Note accepted requests, check accepted words, count cycles.
    always @(posedge i_clk) begin
        fmt_req_t   r;
        text_word_t t;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            r.value = req_ch.value; r.negative = req_ch.negative;
            r.signed_conv = req_ch.signed_conv; r.base = req_ch.base;
            r.fmt_flags = req_ch.fmt_flags; r.field_width = req_ch.field_width;
            r.min_digits = req_ch.min_digits;
            board.note_request(r);
        end
        if (i_rst_n && txt_ch.valid && txt_ch.ready) begin
            t.chars = txt_ch.chars; t.char_count = txt_ch.char_count;
            t.last = txt_ch.last; t.total_length = txt_ch.total_length;
            board.check_word(t);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: stall at random, with stall-free stretches that recur periodically.
    always @(negedge i_clk) begin
        int phase;
        phase = cycle_count % 512;
        if (long_hold) txt_ch.ready <= 0;
        else if (phase < 150) txt_ch.ready <= 1;
        else txt_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // Offer one request and hold it until accepted; gap between bursts.
    task automatic send_request(fmt_req_t r);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 40)) @(negedge i_clk);
            burst_left = $urandom_range(1, 6);
        end
        @(negedge i_clk);
        req_ch.valid       <= 1;
        req_ch.value       <= r.value;
        req_ch.negative    <= r.negative;
        req_ch.signed_conv <= r.signed_conv;
        req_ch.base        <= r.base;
        req_ch.fmt_flags   <= r.fmt_flags;
        req_ch.field_width <= r.field_width;
        req_ch.min_digits  <= r.min_digits;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        req_ch.valid <= 0;
        burst_left--;
    endtask

    task automatic drain_all();
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic fmt_req_t make_req(logic [63:0] v, logic [5:0] b, logic [7:0] fl,
                                          logic [8:0] fw, logic [7:0] md, logic neg,
                                          logic sc);
        fmt_req_t r;
        r.value = v; r.base = b; r.fmt_flags = fl; r.field_width = fw;
        r.min_digits = md; r.negative = neg; r.signed_conv = sc;
        return r;
    endfunction

    function automatic fmt_req_t random_req();
        fmt_req_t r;
        int       pick;
        r.value = {$urandom, $urandom};
        // shrink magnitudes often to reach short digit strings and zero
        case ($urandom_range(0, 3))
            0: r.value = r.value >> $urandom_range(0, 63);
            1: r.value = $urandom_range(0, 2000);
            default: ;
        endcase
        if ($urandom_range(0, 15) == 0) r.value = 0;
        pick = $urandom_range(0, 9);
        r.base = (pick < 3) ? 10 : (pick == 3) ? 16 : (pick == 4) ? 2 : (pick == 5) ? 8
               : (pick == 6) ? $urandom_range(0, 63) : $urandom_range(2, 36);
        r.fmt_flags   = $urandom_range(0, 255);
        r.negative    = $urandom_range(0, 1);
        r.signed_conv = $urandom_range(0, 1);
        r.field_width = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                     : $urandom_range(0, 30);
        r.min_digits  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 25);
        return r;
    endfunction

    initial begin
        fmt_req_t dir[$];
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, every flag, empty field, odd bases, saturation
        dir.push_back(make_req(0, 10, 8'h80, 0, 0, 0, 0));            // empty field
        dir.push_back(make_req(0, 10, 8'h00, 0, 0, 0, 0));
        dir.push_back(make_req('1, 2, 8'h10, 0, 0, 0, 0));            // 64 binary digits
        dir.push_back(make_req('1, 2, 8'h50, 9'h1FF, 8'hFF, 1, 1));   // both saturate
        dir.push_back(make_req('1, 36, 8'h40, 0, 0, 0, 0));
        dir.push_back(make_req('1, 36, 8'h00, 0, 0, 0, 0));
        dir.push_back(make_req(64'd1234567, 10, 8'h20, 0, 0, 1, 1));   // grouping
        dir.push_back(make_req(64'd1234567, 10, 8'hA0, 12, 10, 0, 0));
        dir.push_back(make_req(0, 10, 8'hA0, 5, 0, 0, 0));             // empty, no commas
        dir.push_back(make_req(64'd255, 16, 8'h50, 10, 0, 0, 1));     // 0XFF
        dir.push_back(make_req(64'd255, 16, 8'h10, 10, 0, 0, 0));
        dir.push_back(make_req(64'd8, 8, 8'h18, 10, 0, 0, 0));         // zero pad + alt
        dir.push_back(make_req(64'd5, 2, 8'h11, 10, 0, 0, 0));         // left
        dir.push_back(make_req(64'd42, 10, 8'h02, 6, 0, 0, 1));        // plus
        dir.push_back(make_req(64'd42, 10, 8'h04, 6, 0, 0, 1));        // space
        dir.push_back(make_req(64'd42, 10, 8'h88, 8, 4, 1, 1));        // prec kills zero pad
        dir.push_back(make_req(64'd42, 0, 8'h30, 0, 0, 0, 0));         // base out of range
        dir.push_back(make_req(64'd42, 1, 8'h30, 0, 0, 0, 0));
        dir.push_back(make_req(64'd42, 63, 8'h30, 0, 0, 0, 0));
        dir.push_back(make_req(64'd42, 37, 8'h30, 0, 0, 0, 0));
        dir.push_back(make_req(0, 16, 8'h10, 0, 0, 0, 0));             // alt on zero
        dir.push_back(make_req(64'd7, 10, 8'h09, 256, 0, 1, 1));       // left beats zero
        dir.push_back(make_req(64'd7, 10, 8'h00, 9'h100, 8'h80, 0, 0));
        foreach (dir[i]) send_request(dir[i]);

        // receiver holds off long while requests keep coming
        long_hold = 1;
        fork
            begin
                repeat (3000) @(negedge i_clk);
                long_hold = 0;
            end
            for (int i = 0; i < 6; i++) send_request(random_req());
        join

        // sender waits for everything to drain
        drain_all();
        for (int i = 0; i < 150; i++) begin
            send_request(random_req());
            if (i == 75) drain_all();
        end
        stim_done = 1;
        drain_all();
        repeat (1000) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
